[src/rational_arith_unit_defines.svh]
// Assertion macros for the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define RAU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau assertion failed");

// Check a condition in the cycle after its trigger.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau assertion failed");

`endif

[src/rau_pkg.sv]
// Shared types, codes and helpers for the rational arithmetic unit.
package rau_pkg;

  localparam int WIDTH = 32;
  localparam logic [63:0] HALF = 64'd1 << (WIDTH - 1);

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;

  localparam logic [1:0] ORD_LESS  = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREAT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [2:0] MSEL_L  = 3'd0;
  localparam logic [2:0] MSEL_R  = 3'd1;
  localparam logic [2:0] MSEL_DD = 3'd2;
  localparam logic [2:0] MSEL_NN = 3'd3;
  localparam logic [2:0] MSEL_DN = 3'd4;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       sum;
    logic       gcd_init;
    logic       gcd_step;
    logic       gcd_fin;
    logic       div_init;
    logic       div_sel;
    logic       div_step;
    logic       div_store;
    logic       fin;
  } rau_cmd_t;

  typedef struct packed {
    logic skip;
    logic gcd_done;
  } rau_sts_t;

  function automatic logic [63:0] abs65(input logic signed [64:0] x);
    logic signed [64:0] n;
    n = -x;
    return x[64] ? n[63:0] : x[63:0];
  endfunction

endpackage

[src/rau_dp.sv]
// Datapath: operand registers, shared multiplier, binary GCD and serial divider.
module rau_dp (
  input  logic                clk,
  input  rau_pkg::rau_cmd_t   cmd,
  output rau_pkg::rau_sts_t   sts,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  a_num,
  input  logic signed [31:0]  a_den,
  input  logic signed [31:0]  b_num,
  input  logic signed [31:0]  b_den,
  output logic signed [31:0]  res_num,
  output logic [30:0]         res_den,
  output logic [1:0]          order,
  output logic [1:0]          status
);
  import rau_pkg::*;

  logic [2:0]         mode_r;
  logic signed [32:0] an_r, ad_r, bn_r, bd_r;
  logic               zden_r;
  logic signed [63:0] l_r, r_r, pdd_r, pnn_r, pdn_r;
  logic [63:0]        m_r, d_r;
  logic               neg_r;
  logic [1:0]         ord_r;
  logic [63:0]        u_r, v_r, g_r;
  logic [5:0]         k_r;
  logic [63:0]        quo_r, rem_r;
  logic signed [31:0] res_num_r;
  logic [30:0]        res_den_r;
  logic [1:0]         order_r, status_r;

  logic signed [32:0] an_x, ad_x, bn_x, bd_x, mx, my;
  logic signed [65:0] prod;
  logic signed [64:0] sum_s;
  logic [64:0]        trial;
  logic               tfit;
  logic [63:0]        mneg;
  logic signed [WIDTH-1:0] rn_w;
  logic               ovf;

  always_comb begin
    an_x = 33'(a_num);
    ad_x = 33'(a_den);
    bn_x = 33'(b_num);
    bd_x = 33'(b_den);
    if (a_den[31]) begin
      an_x = -an_x;
      ad_x = -ad_x;
    end
    if (b_den[31]) begin
      bn_x = -bn_x;
      bd_x = -bd_x;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_L:  begin mx = an_r; my = bd_r; end
      MSEL_R:  begin mx = bn_r; my = ad_r; end
      MSEL_DD: begin mx = ad_r; my = bd_r; end
      MSEL_NN: begin mx = an_r; my = bn_r; end
      default: begin mx = ad_r; my = bn_r; end
    endcase
    prod = mx * my;
  end

  assign sum_s = (mode_r == MODE_SUB) ? (65'(l_r) - 65'(r_r)) : (65'(l_r) + 65'(r_r));
  assign trial = {rem_r, quo_r[63]};
  assign tfit  = trial >= {1'b0, g_r};

  assign sts.skip = zden_r || (mode_r > MODE_DIV) || (mode_r == MODE_DIV && bn_r == '0)
                    || (m_r == '0);
  assign sts.gcd_done = (u_r == '0) || (v_r == '0);

  assign mneg = -m_r;
  assign rn_w = neg_r ? mneg[WIDTH-1:0] : m_r[WIDTH-1:0];
  assign ovf  = (d_r > HALF - 64'd1) || (neg_r ? (m_r > HALF) : (m_r > HALF - 64'd1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      an_r   <= an_x;
      ad_r   <= ad_x;
      bn_r   <= bn_x;
      bd_r   <= bd_x;
      zden_r <= (a_den == '0) || (b_den == '0);
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MSEL_L:  l_r   <= prod[63:0];
        MSEL_R:  r_r   <= prod[63:0];
        MSEL_DD: pdd_r <= prod[63:0];
        MSEL_NN: pnn_r <= prod[63:0];
        default: pdn_r <= prod[63:0];
      endcase
    end
    if (cmd.sum) begin
      ord_r <= (l_r < r_r) ? ORD_LESS : ((l_r == r_r) ? ORD_EQUAL : ORD_GREAT);
      priority if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
        m_r   <= abs65(sum_s);
        neg_r <= sum_s[64];
        d_r   <= pdd_r;
      end else if (mode_r == MODE_MUL) begin
        m_r   <= abs65(65'(pnn_r));
        neg_r <= an_r[32] ^ bn_r[32];
        d_r   <= pdd_r;
      end else if (mode_r == MODE_DIV) begin
        m_r   <= abs65(65'(l_r));
        neg_r <= an_r[32] ^ bn_r[32];
        d_r   <= abs65(65'(pdn_r));
      end else begin
        m_r   <= '0;
        neg_r <= 1'b0;
        d_r   <= 64'd1;
      end
    end
    if (cmd.gcd_init) begin
      u_r <= m_r;
      v_r <= d_r;
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 6'd1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
    if (cmd.gcd_fin) g_r <= (u_r | v_r) << k_r;
    if (cmd.div_init) begin
      quo_r <= cmd.div_sel ? d_r : m_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= tfit ? 64'(trial - {1'b0, g_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], tfit};
    end
    // store the finished quotient back into the operand picked by the division select
    if (cmd.div_store) begin
      if (cmd.div_sel) d_r <= quo_r;
      else m_r <= quo_r;
    end
    if (cmd.fin) begin
      priority if (zden_r) begin
        res_num_r <= '0; res_den_r <= '0; order_r <= ORD_LESS; status_r <= ST_ZERO;
      end else if (mode_r == MODE_DIV && bn_r == '0) begin
        res_num_r <= '0; res_den_r <= '0; order_r <= ord_r; status_r <= ST_ZERO;
      end else if (m_r == '0) begin
        res_num_r <= '0; res_den_r <= 31'd1; order_r <= ord_r; status_r <= ST_OK;
      end else if (ovf) begin
        res_num_r <= '0; res_den_r <= '0; order_r <= ord_r; status_r <= ST_OVF;
      end else begin
        res_num_r <= 32'(rn_w); res_den_r <= d_r[30:0];
        order_r <= ord_r; status_r <= ST_OK;
      end
    end
  end

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign order   = order_r;
  assign status  = status_r;

endmodule

[src/rau_ctrl.sv]
// Controller: sequences multiply, reduce and divide steps and owns both handshakes.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rau_pkg::rau_cmd_t cmd,
  input  rau_pkg::rau_sts_t sts
);
  import rau_pkg::*;
  `include "rational_arith_unit_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_CHK, S_GCD, S_DIVM, S_DIVD, S_FIN}
    state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.mul_sel   = cnt_r[2:0];
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 7'd1;
        if (cnt_r[2:0] == MSEL_DN) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.gcd_fin  = 1'b1;
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIVM;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVM: begin
        if (cnt_r == 7'd64) begin
          cmd.div_store = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 7'd1;
        end
      end
      S_DIVD: begin
        cmd.div_sel = 1'b1;
        cnt_nxt     = cnt_r + 7'd1;
        if (cnt_r == 7'd0) begin
          cmd.div_init = 1'b1;
        end else if (cnt_r == 7'd65) begin
          cmd.div_store = 1'b1;
          cnt_nxt       = cnt_r;
          state_nxt     = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RAU_ASSERT_SAME(a_fin_slot, cmd.fin, !out_valid_r || out_tready)
  `RAU_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `RAU_ASSERT_SAME(a_gcd_live, cmd.gcd_step, !sts.gcd_done)

endmodule

[src/rational_arith_unit.sv]
// Binary GCD over 64 bits (one step a cycle) and two restoring divisions do the work;
// zero-denominator, divide-by-zero, compare and zero results skip both.
// Throughput: one item in computation; the next is accepted once the result is registered,
// while that result may still wait on out_tready.
// Reset: synchronous active-low rst_n clears the controller and output valid.
module rational_arith_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // mode[2:0], a_num, a_den, b_num, b_den, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // res_num[31:0], res_den[30:0], order[1:0], status[1:0], pad
);
  import rau_pkg::*;

  rau_cmd_t           cmd;
  rau_sts_t           sts;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         order, status;

  rau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rau_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .mode    (in_tdata[2:0]),
    .a_num   (in_tdata[34:3]),
    .a_den   (in_tdata[66:35]),
    .b_num   (in_tdata[98:67]),
    .b_den   (in_tdata[130:99]),
    .res_num (res_num),
    .res_den (res_den),
    .order   (order),
    .status  (status)
  );

  assign out_tdata = {5'd0, status, order, res_den, res_num};

endmodule

[tb/tb_rational_arith_unit.sv]
// Self-checking testbench for the rational arithmetic unit: fraction ops vs. a local predictor.
module tb_rational_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam logic [2:0] MODE_CMP = 3'd4;
  localparam int WDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  order;
    logic [30:0] den;
    logic [31:0] num;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int errors = 0;

    static function logic [63:0] mag(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    static function logic [63:0] bin_gcd(logic [63:0] u, logic [63:0] v);
      int k;
      logic [63:0] t;
      k = 0;
      while (((u | v) & 64'd1) == 0) begin
        u >>= 1; v >>= 1; k++;
      end
      while ((u & 64'd1) == 0) u >>= 1;
      while (v != 0) begin
        while ((v & 64'd1) == 0) v >>= 1;
        if (u > v) begin
          t = u; u = v; v = t;
        end
        v -= u;
      end
      return u << k;
    endfunction

    static function frac_res_t reduce_op(logic [135:0] td);
      logic [2:0] mode;
      longint an, ad, bn, bd, l, r, s;
      logic neg;
      logic [63:0] m, d, g, half, rn;
      frac_res_t res;
      mode = td[2:0];
      an = $signed(td[34:3]);
      ad = $signed(td[66:35]);
      bn = $signed(td[98:67]);
      bd = $signed(td[130:99]);
      half = 64'h8000_0000;
      res = '0;
      neg = 1'b0;
      m = 0;
      d = 1;
      if (ad == 0 || bd == 0) begin
        res.status = ST_ZERO;
        return res;
      end
      if (ad < 0) begin
        an = -an; ad = -ad;
      end
      if (bd < 0) begin
        bn = -bn; bd = -bd;
      end
      l = an * bd;
      r = bn * ad;
      res.order = l < r ? ORD_LESS : (l == r ? ORD_EQUAL : ORD_GREAT);
      if (mode == MODE_ADD || mode == MODE_SUB) begin
        if (mode == MODE_SUB) r = -r;
        if (l >= 0 && r >= 0) begin
          m = mag(l) + mag(r);
        end else if (l < 0 && r < 0) begin
          neg = 1'b1; m = mag(l) + mag(r);
        end else begin
          s = l + r; neg = s < 0; m = mag(s);
        end
        d = 64'(ad) * 64'(bd);
      end else if (mode == MODE_MUL) begin
        neg = (an < 0) != (bn < 0);
        m = mag(an) * mag(bn);
        d = 64'(ad) * 64'(bd);
      end else if (mode == MODE_DIV) begin
        neg = (an < 0) != (bn < 0);
        m = mag(an) * 64'(bd);
        d = 64'(ad) * mag(bn);
      end
      if (mode == MODE_DIV && bn == 0) begin
        res.status = ST_ZERO;
      end else if (mode >= MODE_CMP || m == 0) begin
        res.den = 31'd1;
      end else begin
        g = bin_gcd(m, d);
        m /= g;
        d /= g;
        if (d > half - 1 || (neg ? m > half : m > half - 1)) begin
          res.status = ST_OVF;
        end else begin
          rn = neg ? -m : m;
          res.num = rn[31:0];
          res.den = d[30:0];
        end
      end
      return res;
    endfunction

    function void note_operands(logic [135:0] td);
      pending.push_back(reduce_op(td));
    endfunction

    function void check_result(logic [71:0] od);
      frac_res_t got, want;
      got = od[66:0];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.num !== want.num || got.den !== want.den || got.order !== want.order ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp num %0d den %0d ord %0d st %0d, got num %0d den %0d ord %0d st %0d",
                   $signed(want.num), want.den, want.order, want.status,
                   $signed(got.num), got.den, got.order, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  frac_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  rational_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_operands(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb_rational_arith_unit NOT OK");
      $finish;
    end
  end

  // Leaves in_tvalid high after the beat; a later idle spell or the caller drops it.
  task automatic send_beat(logic [2:0] mode, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, bd, bn, ad, an, mode};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return 32'($signed($urandom_range(40)) - 20);
    if (pick < 8) return 32'($signed($urandom_range(200000)) - 100000);
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    if ($urandom_range(39) == 0) return 32'd0;
    v = rand_val();
    return v == 0 ? 32'd1 : v;
  endfunction

  task automatic run_random(int count);
    logic [2:0] mode;
    repeat (count) begin
      mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_beat(mode, rand_val(), rand_den(), rand_val(), rand_den());
    end
  endtask

  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'd1;
  localparam logic [31:0] NEG1 = 32'hffff_ffff;

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    for (int m = 0; m < 8; m++) send_beat(3'(m), 32'd3, 32'd4, NEG1, 32'd6);
    send_beat(MODE_ADD, MAXP, ONE, ONE, ONE);
    send_beat(MODE_SUB, MINN, ONE, ONE, ONE);
    send_beat(MODE_SUB, MINN, NEG1, 32'd0, ONE);
    send_beat(MODE_MUL, MINN, MAXP, MAXP, MINN);
    send_beat(MODE_DIV, MINN, ONE, NEG1, ONE);
    send_beat(MODE_DIV, MAXP, 32'd2, 32'd0, 32'd5);
    send_beat(MODE_ADD, ONE, 32'd0, ONE, ONE);
    send_beat(MODE_CMP, ONE, ONE, ONE, 32'd0);
    send_beat(MODE_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    send_beat(MODE_ADD, ONE, MAXP, ONE, 32'h7fff_fffe);
    send_beat(MODE_MUL, MAXP, MINN, NEG1, NEG1);
    send_beat(MODE_CMP, MINN, MINN, MAXP, MAXP);
    send_beat(MODE_DIV, 32'hffff_fff6, 32'hffff_fffc, 32'd15, 32'hffff_fff7);
    send_beat(MODE_MUL, 32'd0, MINN, MINN, ONE);

    // receiver holds off while items keep coming
    hold_left = HOLD_CYCLES;
    run_random(10);

    run_random(220);
    src_idle_pct = 74;
    run_random(220);
    src_idle_pct = 0;
    sink_stall_pct = 74;
    run_random(220);
    src_idle_pct = 30;
    sink_stall_pct = 30;
    run_random(220);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_rational_arith_unit OK");
    end else begin
      $display("tb_rational_arith_unit NOT OK");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/rau_pkg.sv
src/rau_dp.sv
src/rau_ctrl.sv
src/rational_arith_unit.sv
tb/tb_rational_arith_unit.sv
